@@ src/sac_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sac_pkg;

  // Geometry
  localparam int unsigned ADDR_BITS  = 12;
  localparam int unsigned SET_BITS   = 2;
  localparam int unsigned BLOCK_BITS = 2;
  localparam int unsigned WAYS       = 4;
  localparam int unsigned COUNT_BITS = 16;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_W     = 3;
  localparam int unsigned NSETS     = 1 << SET_BITS;
  localparam int unsigned BLK       = 1 << BLOCK_BITS;
  localparam int unsigned NLINES    = NSETS * WAYS;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_BITS;
  localparam int unsigned LB_DEPTH  = NLINES * BLK;

  localparam int unsigned TAG_BITS = ADDR_BITS - SET_BITS - BLOCK_BITS;
  localparam int unsigned TAG_W    = (TAG_BITS > 0) ? TAG_BITS : 1;
  localparam int unsigned SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int unsigned OFF_W    = (BLOCK_BITS > 0) ? BLOCK_BITS : 1;
  localparam int unsigned WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned LINE_W   = (NLINES > 1) ? $clog2(NLINES) : 1;
  localparam int unsigned LB_W     = (LB_DEPTH > 1) ? $clog2(LB_DEPTH) : 1;
  localparam int unsigned FC_W     = BLOCK_BITS + 1;

  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [DATA_W-1:0]     data_t;
  typedef logic [MODE_W-1:0]     mode_t;
  typedef logic [CFG_W-1:0]      cfg_t;
  typedef logic [TAG_W-1:0]      tag_t;
  typedef logic [SET_W-1:0]      set_t;
  typedef logic [OFF_W-1:0]      off_t;
  typedef logic [WAY_W-1:0]      way_t;
  typedef logic [LINE_W-1:0]     line_t;
  typedef logic [LB_W-1:0]       lb_addr_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [FC_W-1:0]       fc_t;

  // Request modes
  localparam mode_t MODE_READ    = 2'd0;
  localparam mode_t MODE_WRITE   = 2'd1;
  localparam mode_t MODE_PRELOAD = 2'd2;

  localparam cfg_t CFG_RESET = 3'd4;

  // Search unit control and status
  typedef struct packed {
    logic clear;
    logic step;
    way_t way;
  } srch_ctl_t;

  typedef struct packed {
    logic hit;
    way_t hit_way;
    way_t victim;
  } srch_st_t;

  function automatic line_t line_idx(set_t s, way_t w);
    line_t r;
    r = LINE_W'(s) * LINE_W'(WAYS) + LINE_W'(w);
    return r;
  endfunction

  function automatic lb_addr_t lb_idx(line_t l, off_t o);
    lb_addr_t r;
    r = (LB_W'(l) << BLOCK_BITS) | LB_W'(o);
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/sac_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface sac_req_if;
  logic                valid;
  logic                ready;
  sac_pkg::mode_t      mode;
  sac_pkg::addr_t      address;
  sac_pkg::data_t      write_data;

  modport source (output valid, output mode, output address, output write_data, input ready);
  modport sink   (input valid, input mode, input address, input write_data, output ready);
endinterface

`default_nettype wire

@@ src/sac_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface sac_rsp_if;
  logic           valid;
  logic           ready;
  sac_pkg::data_t read_data;
  logic           hit;

  modport source (output valid, output read_data, output hit, input ready);
  modport sink   (input valid, input read_data, input hit, output ready);
endinterface

`default_nettype wire

@@ src/sac_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

@@ src/sac_way_search.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One tag compare and one count compare per cycle while step is set, stepped over the ways
module sac_way_search (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sac_pkg::srch_ctl_t ctl_i,
  input  wire sac_pkg::tag_t      req_tag_i,
  input  wire logic               ent_valid_i,
  input  wire sac_pkg::tag_t      ent_tag_i,
  input  wire sac_pkg::count_t    ent_count_i,
  output sac_pkg::srch_st_t       st_o
);

  logic            hit_q, hit_d;
  logic            inv_q, inv_d;
  sac_pkg::way_t   hit_way_q, hit_way_d;
  sac_pkg::way_t   victim_q, victim_d;
  sac_pkg::count_t best_q, best_d;

  // Running hit flag and replacement candidate
  always_comb begin
    hit_d     = hit_q;
    inv_d     = inv_q;
    hit_way_d = hit_way_q;
    victim_d  = victim_q;
    best_d    = best_q;
    if (ctl_i.clear) begin
      hit_d     = 1'b0;
      inv_d     = 1'b0;
      hit_way_d = '0;
      victim_d  = '0;
      best_d    = '1;
    end else if (ctl_i.step) begin
      if (ent_valid_i && (ent_tag_i == req_tag_i) && !hit_q) begin
        hit_d     = 1'b1;
        hit_way_d = ctl_i.way;
      end
      // first invalid way wins, else strictly lower count
      priority if (!ent_valid_i && !inv_q) begin
        inv_d    = 1'b1;
        victim_d = ctl_i.way;
      end else if (ent_valid_i && !inv_q && (ent_count_i < best_q)) begin
        best_d   = ent_count_i;
        victim_d = ctl_i.way;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q     <= 1'b0;
      inv_q     <= 1'b0;
      hit_way_q <= '0;
      victim_q  <= '0;
      best_q    <= '1;
    end else begin
      hit_q     <= hit_d;
      inv_q     <= inv_d;
      hit_way_q <= hit_way_d;
      victim_q  <= victim_d;
      best_q    <= best_d;
    end
  end

  assign st_o.hit     = hit_q;
  assign st_o.hit_way = hit_way_q;
  assign st_o.victim  = victim_q;

endmodule

`default_nettype wire

@@ src/set_assoc_cache_lfu_write_through.sv @@
// One request per pass; the way search steps through the active ways one at a time.
// Read hit: accept, search, check, line byte read, finish; write hit: accept, search,
// check and line byte write, finish; miss: accept, search, check, block fill (one
// backing memory byte per cycle), finish. Preload and unknown modes go from accept
// to finish. A new request is taken after the result is placed in the output register.
// Reset clears line valid, tags and use counts at once and sets ways_q to 4.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_lfu_write_through (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire sac_pkg::cfg_t cfg_wdata_i,
  sac_req_if.sink            req_i,
  sac_rsp_if.source          rsp_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_HRD    = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_q, state_d;

  sac_pkg::cfg_t  ways_q;
  sac_pkg::mode_t mode_q;
  sac_pkg::addr_t addr_q;
  sac_pkg::data_t wdata_q;
  sac_pkg::tag_t  tag_q;
  sac_pkg::set_t  set_q;
  sac_pkg::off_t  off_q;
  sac_pkg::way_t  last_way_q, last_way;
  sac_pkg::way_t  way_q, way_d;
  sac_pkg::fc_t   fc_q, fc_d;
  sac_pkg::line_t line_q, line_d;
  sac_pkg::data_t res_rd_q, res_rd_d;
  logic           res_hit_q, res_hit_d;
  logic           out_vld_q;
  sac_pkg::data_t out_rd_q;
  logic           out_hit_q;
  logic           out_load;

  // Line directory
  logic            valid_q [sac_pkg::NLINES];
  sac_pkg::tag_t   tag_arr_q [sac_pkg::NLINES];
  sac_pkg::count_t cnt_q [sac_pkg::NLINES];

  sac_pkg::srch_ctl_t srch_ctl;
  sac_pkg::srch_st_t  srch_st;
  sac_pkg::line_t     rd_line;
  sac_pkg::line_t     hit_line;
  sac_pkg::line_t     vic_line;
  sac_pkg::off_t      fprev;

  logic             lb_we;
  sac_pkg::lb_addr_t lb_addr;
  sac_pkg::data_t   lb_wdata, lb_rdata;
  logic             mem_we;
  sac_pkg::addr_t   mem_addr;
  sac_pkg::data_t   mem_rdata;
  logic             accept;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && (state_q == S_IDLE);

  // Clamp the configured way count to a last way index
  always_comb begin
    priority if (ways_q == '0) begin
      last_way = '0;
    end else if ({1'b0, ways_q} > (sac_pkg::CFG_W + 1)'(sac_pkg::WAYS)) begin
      last_way = sac_pkg::WAY_W'(sac_pkg::WAYS - 1);
    end else begin
      last_way = sac_pkg::WAY_W'(ways_q - sac_pkg::CFG_W'(1));
    end
  end

  assign rd_line  = sac_pkg::line_idx(set_q, way_q);
  assign hit_line = sac_pkg::line_idx(set_q, srch_st.hit_way);
  assign vic_line = sac_pkg::line_idx(set_q, srch_st.victim);
  assign fprev    = sac_pkg::OFF_W'(fc_q - sac_pkg::FC_W'(1));

  // Sequencer
  always_comb begin
    state_d   = state_q;
    way_d     = way_q;
    fc_d      = fc_q;
    line_d    = line_q;
    res_rd_d  = res_rd_q;
    res_hit_d = res_hit_q;
    srch_ctl       = '0;
    srch_ctl.way   = way_q;
    lb_we     = 1'b0;
    lb_addr   = sac_pkg::lb_idx(line_q, off_q);
    lb_wdata  = wdata_q;
    mem_we    = 1'b0;
    mem_addr  = req_i.address;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          res_rd_d       = '0;
          res_hit_d      = 1'b0;
          way_d          = '0;
          srch_ctl.clear = 1'b1;
          mem_we = (req_i.mode == sac_pkg::MODE_WRITE) ||
                   (req_i.mode == sac_pkg::MODE_PRELOAD);
          if ((req_i.mode == sac_pkg::MODE_READ) || (req_i.mode == sac_pkg::MODE_WRITE)) begin
            state_d = S_SEARCH;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_SEARCH: begin
        srch_ctl.step = 1'b1;
        way_d         = way_q + sac_pkg::WAY_W'(1);
        if (way_q == last_way_q) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (srch_st.hit) begin
          res_hit_d = 1'b1;
          lb_addr   = sac_pkg::lb_idx(hit_line, off_q);
          if (mode_q == sac_pkg::MODE_READ) begin
            state_d = S_HRD;
          end else begin
            lb_we   = 1'b1;
            state_d = S_FINISH;
          end
        end else begin
          line_d  = vic_line;
          fc_d    = '0;
          state_d = S_FILL;
        end
      end
      S_HRD: begin
        res_rd_d = lb_rdata;
        state_d  = S_FINISH;
      end
      S_FILL: begin
        // issue byte fc_q, store byte fc_q - 1
        mem_addr = (addr_q & ~sac_pkg::ADDR_BITS'(sac_pkg::BLK - 1)) |
                   sac_pkg::ADDR_BITS'(fc_q);
        if (fc_q != '0) begin
          lb_we    = 1'b1;
          lb_addr  = sac_pkg::lb_idx(line_q, fprev);
          lb_wdata = mem_rdata;
          if (fprev == off_q) begin
            if (mode_q == sac_pkg::MODE_WRITE) begin
              lb_wdata = wdata_q;
            end else begin
              res_rd_d = mem_rdata;
            end
          end
        end
        if (fc_q == sac_pkg::FC_W'(sac_pkg::BLK)) begin
          state_d = S_FINISH;
        end else begin
          fc_d = fc_q + sac_pkg::FC_W'(1);
        end
      end
      S_FINISH: begin
        if (!out_vld_q || rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_load = (state_q == S_FINISH) && (!out_vld_q || rsp_o.ready);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ways_q    <= sac_pkg::CFG_RESET;
      way_q     <= '0;
      fc_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      way_q   <= way_d;
      fc_q    <= fc_d;
      if (cfg_we_i) begin
        ways_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q     <= req_i.mode;
      addr_q     <= req_i.address;
      wdata_q    <= req_i.write_data;
      tag_q      <= sac_pkg::TAG_W'(req_i.address >> (sac_pkg::SET_BITS + sac_pkg::BLOCK_BITS));
      set_q      <= sac_pkg::SET_W'((req_i.address >> sac_pkg::BLOCK_BITS) &
                                    sac_pkg::ADDR_BITS'(sac_pkg::NSETS - 1));
      off_q      <= sac_pkg::OFF_W'(req_i.address & sac_pkg::ADDR_BITS'(sac_pkg::BLK - 1));
      last_way_q <= last_way;
    end
    line_q    <= line_d;
    res_rd_q  <= res_rd_d;
    res_hit_q <= res_hit_d;
    if (out_load) begin
      out_rd_q  <= res_rd_q;
      out_hit_q <= res_hit_q;
    end
  end

  // Directory update: bump on hit, allocate on miss
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sac_pkg::NLINES; i++) begin
        valid_q[i]   <= 1'b0;
        tag_arr_q[i] <= '0;
        cnt_q[i]     <= '0;
      end
    end else if (state_q == S_CHECK) begin
      if (srch_st.hit) begin
        if (cnt_q[hit_line] != '1) begin
          cnt_q[hit_line] <= cnt_q[hit_line] + sac_pkg::COUNT_BITS'(1);
        end
      end else begin
        valid_q[vic_line]   <= 1'b1;
        tag_arr_q[vic_line] <= tag_q;
        cnt_q[vic_line]     <= (mode_q == sac_pkg::MODE_WRITE) ?
                               sac_pkg::COUNT_BITS'(2) : sac_pkg::COUNT_BITS'(1);
      end
    end
  end

  sac_way_search u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (srch_ctl),
    .req_tag_i   (tag_q),
    .ent_valid_i (valid_q[rd_line]),
    .ent_tag_i   (tag_arr_q[rd_line]),
    .ent_count_i (cnt_q[rd_line]),
    .st_o        (srch_st)
  );

  sac_ram #(
    .WIDTH (sac_pkg::DATA_W),
    .DEPTH (sac_pkg::LB_DEPTH)
  ) u_line_bytes (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .addr_i  (lb_addr),
    .wdata_i (lb_wdata),
    .rdata_o (lb_rdata)
  );

  sac_ram #(
    .WIDTH (sac_pkg::DATA_W),
    .DEPTH (sac_pkg::MEM_DEPTH)
  ) u_backing (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (req_i.write_data),
    .rdata_o (mem_rdata)
  );

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.read_data = out_rd_q;
  assign rsp_o.hit       = out_hit_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> (fc_q <= sac_pkg::FC_W'(sac_pkg::BLK)))
    else $error("fill counter past block end");

  a_way_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (way_q <= last_way_q))
    else $error("search beyond active ways");

  a_miss_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_CHECK) && !srch_st.hit) |=> ((state_q == S_FILL) && valid_q[line_q]))
    else $error("miss did not allocate a valid line");

  a_hit_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FINISH) && res_hit_q) |->
      ((mode_q == sac_pkg::MODE_READ) || (mode_q == sac_pkg::MODE_WRITE)))
    else $error("hit reported for preload or unknown mode");
`endif

endmodule

`default_nettype wire
